[design/jmt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// jmt_pkg
// Shared types and constants of the joint motion transform.
// -----------------------------------------------------------------------------
package jmt_pkg;

   // joint kinds
   typedef enum logic [1:0] {
      KIND_FIXED      = 2'd0,
      KIND_REVOLUTE   = 2'd1,
      KIND_PRISMATIC  = 2'd2,
      KIND_CONTINUOUS = 2'd3
   } kind_type;

   // register indexes
   localparam logic [1:0] REG_KIND   = 2'd0;
   localparam logic [1:0] REG_AXIS_X = 2'd1;
   localparam logic [1:0] REG_AXIS_Y = 2'd2;
   localparam logic [1:0] REG_AXIS_Z = 2'd3;

   localparam int FRAC_BITS = 16;  // fractional bits of the position, axis and output fields
   localparam int ANG_BITS = 30;
   localparam int ANG_W    = 36;   // Q30 angle register width
   localparam int CX_W     = 34;   // CORDIC x/y width
   localparam int ATAN_LEN = 24;

   localparam logic signed [ANG_W-1:0] TWO_PI  = 36'sd6746518852;
   localparam logic signed [ANG_W-1:0] PI      = 36'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI = 36'sd1686629713;
   localparam logic signed [CX_W-1:0]  GAIN    = 34'sd652032874;

   // atan(2^-i) in Q30
   function automatic logic signed [ANG_W-1:0] atan_q(input int i);
      logic signed [ANG_W-1:0] v;
      v = '0;
      case (i)
         0:  v = 36'sd843314856;
         1:  v = 36'sd497837829;
         2:  v = 36'sd263043836;
         3:  v = 36'sd133525158;
         4:  v = 36'sd67021686;
         5:  v = 36'sd33543515;
         6:  v = 36'sd16775850;
         7:  v = 36'sd8388437;
         8:  v = 36'sd4194282;
         9:  v = 36'sd2097149;
         10: v = 36'sd1048575;
         11: v = 36'sd524287;
         12: v = 36'sd262143;
         13: v = 36'sd131071;
         14: v = 36'sd65535;
         15: v = 36'sd32767;
         16: v = 36'sd16383;
         17: v = 36'sd8191;
         18: v = 36'sd4095;
         19: v = 36'sd2047;
         20: v = 36'sd1023;
         21: v = 36'sd511;
         22: v = 36'sd255;
         23: v = 36'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

[design/joint_motion_transform_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// joint_motion_transform_top
// Joint position in, rotation matrix and translation out, fully pipelined.
// -----------------------------------------------------------------------------
// Channel | Dir | Contents
// req_    | in  | tdata[23:0] joint_position
// rsp_    | out | tdata: rot_00..rot_22 (18b each), shift_x/y/z (24b each)
// csr_    | in  | we, index, 18b write data
//
// Stages A, B, C, the CORDIC, D, E, F, output register; one transaction per cycle when not stalled.
// The pipeline depth is set by the CORDIC, one stage per iteration.
// Stalls freeze every stage at once (global enable = output free or empty).
// Reset clears all valid bits and loads the reset register values.
// -----------------------------------------------------------------------------
module joint_motion_transform_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [23:0]  req_tdata,   // [23:0] joint_position
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [239:0] rsp_tdata,   // rot_00,01,02,10,11,12,20,21,22 (18b), shift_x,y,z (24b)
   input  wire          csr_we,
   input  wire  [1:0]   csr_index,
   input  wire  [17:0]  csr_wdata
);

   localparam int FRAC_BITS = jmt_pkg::FRAC_BITS;
   localparam int AW   = jmt_pkg::ANG_W;
   localparam int CW   = jmt_pkg::CX_W;
   localparam int NS   = (CORDIC_STEPS < jmt_pkg::ATAN_LEN) ? CORDIC_STEPS
                                                             : jmt_pkg::ATAN_LEN;
   localparam int RS   = jmt_pkg::ANG_BITS - FRAC_BITS;
   localparam int ONE  = 1 << FRAC_BITS;

   // ---------------------------------------------------------------- registers
   jmt_pkg::kind_type     kind_ff;
   logic signed [17:0]    axis_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff    <= jmt_pkg::KIND_FIXED;
         axis_ff[0] <= '0;
         axis_ff[1] <= '0;
         axis_ff[2] <= 18'sd65536;
      end else if (csr_we) begin
         case (csr_index)
            jmt_pkg::REG_KIND:   kind_ff    <= jmt_pkg::kind_type'(csr_wdata[1:0]);
            jmt_pkg::REG_AXIS_X: axis_ff[0] <= csr_wdata;
            jmt_pkg::REG_AXIS_Y: axis_ff[1] <= csr_wdata;
            jmt_pkg::REG_AXIS_Z: axis_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ------------------------------------------------- stage A: scale and mod
   // q*2^RS fits 38 bits, at most ~21 multiples of 2pi. Coarse multiple from
   // a reciprocal multiply on q; it is off by at most one, fixed up in stage C.
   logic              a_v_ff;
   logic signed [23:0] a_q_ff;
   logic signed [39:0] a_ang_ff;
   logic signed [5:0]  a_mult_ff;   // floor(ang / 2pi) estimate

   logic signed [39:0] ang_w;
   logic signed [39:0] est_w;
   // floor(2^(RS+32) / TWO_PI) for RS = 14
   localparam logic signed [39:0] RECIP = 40'sd10430;
   assign ang_w = 40'(signed'(req_tdata)) <<< RS;
   assign est_w = 40'(signed'(req_tdata)) * RECIP;

   always_ff @(posedge clock) begin
      if (reset) a_v_ff <= 1'b0;
      else if (adv) a_v_ff <= req_tvalid;
      if (adv) begin
         a_q_ff    <= req_tdata;
         a_ang_ff  <= ang_w;
         a_mult_ff <= 6'(est_w >>> 32);
      end
   end

   // ------------------------------------------------- stage B: subtract multiple
   logic              b_v_ff;
   logic signed [23:0] b_q_ff;
   logic signed [39:0] b_r_ff;
   logic signed [39:0] sub_w;
   assign sub_w = 40'(a_mult_ff) * 40'(jmt_pkg::TWO_PI);
   always_ff @(posedge clock) begin
      if (reset) b_v_ff <= 1'b0;
      else if (adv) b_v_ff <= a_v_ff;
      if (adv) begin
         b_q_ff <= a_q_ff;
         b_r_ff <= a_ang_ff - sub_w;
      end
   end

   // ------------------------------------------------- stage C: fix-up and fold
   // estimate is off by at most one multiple either way
   logic              c_v_ff;
   logic signed [23:0] c_q_ff;
   logic signed [AW-1:0] c_z_ff;
   logic              c_neg_ff;
   logic signed [39:0] r0, r1;
   logic signed [39:0] tp, pp, hp;
   logic              neg_w;
   assign tp = 40'(jmt_pkg::TWO_PI);
   assign pp = 40'(jmt_pkg::PI);
   assign hp = 40'(jmt_pkg::HALF_PI);
   always_comb begin
      r0 = b_r_ff;
      if (r0 < 0) r0 = r0 + tp;
      else if (r0 >= tp) r0 = r0 - tp;
      if (r0 >= pp) r0 = r0 - tp;
      neg_w = 1'b0;
      r1 = r0;
      if (r0 > hp) begin
         r1 = r0 - pp; neg_w = 1'b1;
      end else if (r0 < -hp) begin
         r1 = r0 + pp; neg_w = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (reset) c_v_ff <= 1'b0;
      else if (adv) c_v_ff <= b_v_ff;
      if (adv) begin
         c_q_ff   <= b_q_ff;
         c_z_ff   <= AW'(r1);
         c_neg_ff <= neg_w;
      end
   end

   // ------------------------------------------------- CORDIC, one stage each
   logic              cv_ff  [NS+1];
   logic signed [CW-1:0] cx_ff [NS+1];
   logic signed [CW-1:0] cy_ff [NS+1];
   logic signed [AW-1:0] cz_ff [NS+1];
   logic              cn_ff  [NS+1];
   logic signed [23:0] cq_ff [NS+1];

   assign cv_ff[0] = c_v_ff;
   assign cx_ff[0] = jmt_pkg::GAIN;
   assign cy_ff[0] = '0;
   assign cz_ff[0] = c_z_ff;
   assign cn_ff[0] = c_neg_ff;
   assign cq_ff[0] = c_q_ff;

   for (genvar i = 0; i < NS; i++) begin : g_cordic
      logic signed [CW-1:0] x_ff, y_ff;
      logic signed [AW-1:0] z_ff;
      logic v_ff, n_ff;
      logic signed [23:0] q_ff;
      always_ff @(posedge clock) begin
         if (reset) v_ff <= 1'b0;
         else if (adv) v_ff <= cv_ff[i];
         if (adv) begin
            n_ff <= cn_ff[i];
            q_ff <= cq_ff[i];
            if (cz_ff[i] >= 0) begin
               x_ff <= cx_ff[i] - (cy_ff[i] >>> i);
               y_ff <= cy_ff[i] + (cx_ff[i] >>> i);
               z_ff <= cz_ff[i] - jmt_pkg::atan_q(i);
            end else begin
               x_ff <= cx_ff[i] + (cy_ff[i] >>> i);
               y_ff <= cy_ff[i] - (cx_ff[i] >>> i);
               z_ff <= cz_ff[i] + jmt_pkg::atan_q(i);
            end
         end
      end
      assign cv_ff[i+1] = v_ff;
      assign cx_ff[i+1] = x_ff;
      assign cy_ff[i+1] = y_ff;
      assign cz_ff[i+1] = z_ff;
      assign cn_ff[i+1] = n_ff;
      assign cq_ff[i+1] = q_ff;
   end

   // ------------------------------------------------- stage D: round c, s
   logic              d_v_ff;
   logic signed [23:0] d_q_ff;
   logic signed [19:0] d_c_ff, d_s_ff;
   logic signed [CW:0] xs, ys;
   always_comb begin
      xs = cn_ff[NS] ? -(CW+1)'(cx_ff[NS]) : (CW+1)'(cx_ff[NS]);
      ys = cn_ff[NS] ? -(CW+1)'(cy_ff[NS]) : (CW+1)'(cy_ff[NS]);
   end
   always_ff @(posedge clock) begin
      if (reset) d_v_ff <= 1'b0;
      else if (adv) d_v_ff <= cv_ff[NS];
      if (adv) begin
         d_q_ff <= cq_ff[NS];
         d_c_ff <= 20'((xs + ((CW+1)'(1) <<< (RS-1))) >>> RS);
         d_s_ff <= 20'((ys + ((CW+1)'(1) <<< (RS-1))) >>> RS);
      end
   end

   // ------------------------------------------------- stage E: kk, sk, prismatic
   logic              e_v_ff;
   logic signed [19:0] e_c_ff;
   logic signed [20:0] e_t_ff;
   logic signed [20:0] e_kk_ff [6];   // 00 01 02 11 12 22
   logic signed [23:0] e_sk_ff [3];
   logic signed [23:0] e_sh_ff [3];
   localparam int P_W = 44;
   function automatic logic signed [P_W-1:0] rndf(input logic signed [P_W-1:0] v);
      return (v + (P_W'(1) <<< (FRAC_BITS-1))) >>> FRAC_BITS;
   endfunction
   function automatic logic signed [23:0] sat24(input logic signed [P_W-1:0] v);
      if (v > P_W'(24'sh7fffff)) return 24'sh7fffff;
      if (v < -(P_W'(1) <<< 23)) return 24'sh800000;
      return 24'(v);
   endfunction
   always_ff @(posedge clock) begin
      if (reset) e_v_ff <= 1'b0;
      else if (adv) e_v_ff <= d_v_ff;
      if (adv) begin
         e_c_ff <= d_c_ff;
         e_t_ff <= 21'(ONE) - 21'(d_c_ff);
         e_kk_ff[0] <= 21'(rndf(P_W'(axis_ff[0]) * P_W'(axis_ff[0])));
         e_kk_ff[1] <= 21'(rndf(P_W'(axis_ff[0]) * P_W'(axis_ff[1])));
         e_kk_ff[2] <= 21'(rndf(P_W'(axis_ff[0]) * P_W'(axis_ff[2])));
         e_kk_ff[3] <= 21'(rndf(P_W'(axis_ff[1]) * P_W'(axis_ff[1])));
         e_kk_ff[4] <= 21'(rndf(P_W'(axis_ff[1]) * P_W'(axis_ff[2])));
         e_kk_ff[5] <= 21'(rndf(P_W'(axis_ff[2]) * P_W'(axis_ff[2])));
         for (int j = 0; j < 3; j++) begin
            e_sk_ff[j] <= 24'(rndf(P_W'(d_s_ff) * P_W'(axis_ff[j])));
            e_sh_ff[j] <= sat24(rndf(P_W'(axis_ff[j]) * P_W'(d_q_ff)));
         end
      end
   end

   // ------------------------------------------------- stage F: t * kk
   logic              f_v_ff;
   logic signed [19:0] f_c_ff;
   logic signed [26:0] f_tk_ff [6];
   logic signed [23:0] f_sk_ff [3];
   logic signed [23:0] f_sh_ff [3];
   always_ff @(posedge clock) begin
      if (reset) f_v_ff <= 1'b0;
      else if (adv) f_v_ff <= e_v_ff;
      if (adv) begin
         f_c_ff <= e_c_ff;
         for (int j = 0; j < 6; j++)
            f_tk_ff[j] <= 27'(rndf(P_W'(e_t_ff) * P_W'(e_kk_ff[j])));
         f_sk_ff <= e_sk_ff;
         f_sh_ff <= e_sh_ff;
      end
   end

   // ------------------------------------------------- stage G: assemble, saturate
   function automatic logic [17:0] sat18(input logic signed [27:0] v);
      if (v > 28'sd131071) return 18'h1ffff;
      if (v < -28'sd131072) return 18'h20000;
      return 18'(v);
   endfunction
   logic [17:0] rot_w [9];
   logic [23:0] sh_w  [3];
   logic        rotating;
   logic signed [27:0] cc;
   always_comb begin
      rotating = (kind_ff == jmt_pkg::KIND_REVOLUTE) ||
                 (kind_ff == jmt_pkg::KIND_CONTINUOUS);
      cc = 28'(f_c_ff);
      for (int j = 0; j < 9; j++) rot_w[j] = '0;
      for (int j = 0; j < 3; j++) sh_w[j] = '0;
      if (rotating) begin
         rot_w[0] = sat18(cc + 28'(f_tk_ff[0]));
         rot_w[1] = sat18(28'(f_tk_ff[1]) - 28'(f_sk_ff[2]));
         rot_w[2] = sat18(28'(f_tk_ff[2]) + 28'(f_sk_ff[1]));
         rot_w[3] = sat18(28'(f_tk_ff[1]) + 28'(f_sk_ff[2]));
         rot_w[4] = sat18(cc + 28'(f_tk_ff[3]));
         rot_w[5] = sat18(28'(f_tk_ff[4]) - 28'(f_sk_ff[0]));
         rot_w[6] = sat18(28'(f_tk_ff[2]) - 28'(f_sk_ff[1]));
         rot_w[7] = sat18(28'(f_tk_ff[4]) + 28'(f_sk_ff[0]));
         rot_w[8] = sat18(cc + 28'(f_tk_ff[5]));
      end else begin
         rot_w[0] = sat18(28'(ONE));
         rot_w[4] = sat18(28'(ONE));
         rot_w[8] = sat18(28'(ONE));
         if (kind_ff == jmt_pkg::KIND_PRISMATIC) begin
            for (int j = 0; j < 3; j++) sh_w[j] = f_sh_ff[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_tvalid <= 1'b0;
      else if (adv) rsp_tvalid <= f_v_ff;
      if (adv) begin
         rsp_tdata <= {6'd0, sh_w[2], sh_w[1], sh_w[0], rot_w[8], rot_w[7], rot_w[6],
                       rot_w[5], rot_w[4], rot_w[3], rot_w[2], rot_w[1], rot_w[0]};
      end
   end

   // ------------------------------------------------- assertions
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");
   a_valid_flow: assert property (@(posedge clock) disable iff (reset)
      adv && f_v_ff |=> rsp_tvalid)
      else $error("pipeline valid lost");

endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the joint motion transform. Joint positions stream
// in with bursty gaps while the result side stalls on its own pattern; every
// result is checked field by field against a bit-exact predictor of the
// CORDIC and Rodrigues arithmetic, over all joint kinds and several axes.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int LATENCY = 3 + 16 + 4;
   localparam int FRAC    = 16;
   localparam int STEPS   = 16;

   typedef struct {
      logic signed [17:0] rot [9];
      logic signed [23:0] shift [3];
   } xform_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [239:0] rsp_tdata;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [17:0]  csr_wdata = '0;

   joint_motion_transform_top u_top (.*);

   always #6 clock = ~clock;

   // predictor's copy of the registers
   jmt_pkg::kind_type  kind_q = jmt_pkg::KIND_FIXED;
   logic signed [17:0] axis_q [3] = '{18'sd0, 18'sd0, 18'sd65536};

   logic [23:0] position_q [$];
   xform_type   xform_q [$];
   int          errors = 0;
   int          checked = 0;
   int          cycles = 0;
   bit          hold_req = 1'b0;

   function automatic longint floor_sh(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint round_sh(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
   endfunction

   function automatic longint clamp(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) << (w - 1)) - 1;
      lo = -(longint'(1) << (w - 1));
      return v > hi ? hi : (v < lo ? lo : v);
   endfunction

   function automatic longint arctan_q30(int i);
      longint tab [24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
         33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287,
         262143, 131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511,
         255, 127};
      return tab[i];
   endfunction

   function automatic xform_type joint_transform(logic [23:0] raw);
      xform_type res;
      longint  q, r, x, y, z, dx, dy, c, s, t, one;
      longint  rot [9];
      longint  tk [3][3];
      longint  sk [3];
      longint  k [3];
      bit      neg;
      q = longint'($signed(raw));
      one = longint'(1) << FRAC;
      for (int j = 0; j < 3; j++) k[j] = longint'(axis_q[j]);
      rot = '{one, 0, 0, 0, one, 0, 0, 0, one};
      for (int j = 0; j < 3; j++) res.shift[j] = '0;
      if (kind_q == jmt_pkg::KIND_REVOLUTE || kind_q == jmt_pkg::KIND_CONTINUOUS) begin
         // angle reduction into [-pi/2, pi/2] with sign flip
         r = (q * (longint'(1) << (30 - FRAC))) % 64'sd6746518852;
         if (r < 0) r += 64'sd6746518852;
         if (r >= 64'sd3373259426) r -= 64'sd6746518852;
         neg = 1'b0;
         if (r > 64'sd1686629713) begin
            r -= 64'sd3373259426;
            neg = 1'b1;
         end else if (r < -64'sd1686629713) begin
            r += 64'sd3373259426;
            neg = 1'b1;
         end
         x = 652032874;
         y = 0;
         z = r;
         for (int i = 0; i < STEPS; i++) begin
            dx = floor_sh(y, i);
            dy = floor_sh(x, i);
            if (z >= 0) begin
               x -= dx; y += dy; z -= arctan_q30(i);
            end else begin
               x += dx; y -= dy; z += arctan_q30(i);
            end
         end
         if (neg) begin
            x = -x;
            y = -y;
         end
         c = round_sh(x, 30 - FRAC);
         s = round_sh(y, 30 - FRAC);
         t = one - c;
         for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++)
               tk[a][b] = round_sh(t * round_sh(k[a] * k[b], FRAC), FRAC);
            sk[a] = round_sh(s * k[a], FRAC);
         end
         rot[0] = c + tk[0][0];
         rot[1] = tk[0][1] - sk[2];
         rot[2] = tk[0][2] + sk[1];
         rot[3] = tk[0][1] + sk[2];
         rot[4] = c + tk[1][1];
         rot[5] = tk[1][2] - sk[0];
         rot[6] = tk[0][2] - sk[1];
         rot[7] = tk[1][2] + sk[0];
         rot[8] = c + tk[2][2];
      end else if (kind_q == jmt_pkg::KIND_PRISMATIC) begin
         for (int j = 0; j < 3; j++)
            res.shift[j] = 24'(clamp(round_sh(k[j] * q, FRAC), 24));
      end
      for (int j = 0; j < 9; j++) res.rot[j] = 18'(clamp(rot[j], 18));
      return res;
   endfunction

   // driver: bursts of random length separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            xform_q.push_back(joint_transform(req_tdata));
         if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (position_q.size() > 0 && gap_left == 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= position_q.pop_front();
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end else begin
            req_tvalid <= 1'b0;
            if (gap_left > 0) gap_left--;
         end
      end
   end

   // receiver stall pattern, plus one long hold-off counted here
   int stall_mode = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   always @(posedge clock) begin
      if ((cycles % 400) == 0) stall_mode <= $urandom_range(0, 3);
      if (hold_req && !hold_done) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
      if (reset || hold_left > 0 || (hold_req && !hold_done))
         rsp_tready <= 1'b0;
      else case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 3) != 0);
         2: rsp_tready <= ((cycles % 7) < 3);
         default: rsp_tready <= ($urandom_range(0, 1) == 1);
      endcase
   end

   // monitor: compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      xform_type want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (xform_q.size() == 0) begin
            $error("unexpected result transaction %h", rsp_tdata);
            errors++;
         end else begin
            want = xform_q.pop_front();
            for (int j = 0; j < 9; j++)
               if (rsp_tdata[18*j +: 18] !== want.rot[j]) begin
                  $error("rot_%0d%0d expected %0d actual %0d", j / 3, j % 3,
                         want.rot[j], $signed(rsp_tdata[18*j +: 18]));
                  errors++;
               end
            for (int j = 0; j < 3; j++)
               if (rsp_tdata[162 + 24*j +: 24] !== want.shift[j]) begin
                  $error("shift_%s expected %0d actual %0d", j == 0 ? "x" : j == 1 ? "y" : "z",
                         want.shift[j], $signed(rsp_tdata[162 + 24*j +: 24]));
                  errors++;
               end
            checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (cycles > 400000) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [17:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == jmt_pkg::REG_KIND) kind_q = jmt_pkg::kind_type'(val[1:0]);
      else axis_q[idx - 1] = $signed(val);
   endtask

   task automatic drain_pipe();
      wait (position_q.size() == 0 && !req_tvalid);
      wait (xform_q.size() == 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic set_pose(jmt_pkg::kind_type kd, logic [17:0] ax, logic [17:0] ay,
                           logic [17:0] az);
      drain_pipe();
      write_reg(jmt_pkg::REG_KIND, 18'(kd));
      write_reg(jmt_pkg::REG_AXIS_X, ax);
      write_reg(jmt_pkg::REG_AXIS_Y, ay);
      write_reg(jmt_pkg::REG_AXIS_Z, az);
   endtask

   function automatic logic [23:0] rand_position();
      case ($urandom_range(0, 4))
         0: return 24'($urandom_range(0, 32'h00ffffff));
         1: return 24'($signed($urandom_range(0, 16'hffff)) - 32'sd32768) <<< 0;
         2: return 24'(32'sd411775 - 32'($urandom_range(0, 823550)));
         3: return {$urandom_range(0, 1) ? 4'hf : 4'h0, 20'($urandom())};
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic logic [17:0] rand_axis();
      case ($urandom_range(0, 5))
         0: return 18'sd65536;
         1: return -18'sd65536;
         2: return 18'sd46341;
         3: return 18'h1ffff;
         4: return 18'h20000;
         default: return 18'($urandom());
      endcase
   endfunction

   initial begin
      logic [23:0] edges [12];
      jmt_pkg::kind_type kinds [4];
      edges = '{24'h000000, 24'h7fffff, 24'h800000, 24'hffffff,
         24'h019220, 24'h03243f, 24'h06487f, 24'hfcdbc1, 24'h01921f, 24'h0c90fe,
         24'hfe6de0, 24'h555555};
      kinds = '{jmt_pkg::KIND_FIXED, jmt_pkg::KIND_REVOLUTE, jmt_pkg::KIND_PRISMATIC,
                jmt_pkg::KIND_CONTINUOUS};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: edge positions for every kind on the reset axis
      foreach (kinds[i]) begin
         set_pose(kinds[i], 18'sd0, 18'sd0, 18'sd65536);
         for (int j = 0; j < 6; j++) position_q.push_back(edges[j + (i % 2) * 6]);
      end
      // non-unit, extreme axes saturate
      set_pose(jmt_pkg::KIND_REVOLUTE, 18'h1ffff, 18'h20000, 18'h1ffff);
      foreach (edges[j]) position_q.push_back(edges[j]);
      set_pose(jmt_pkg::KIND_PRISMATIC, 18'h1ffff, 18'h20000, 18'h00001);
      for (int j = 0; j < 4; j++) position_q.push_back(edges[j]);

      // random phases over settings
      for (int ph = 0; ph < 12; ph++) begin
         set_pose(kinds[$urandom_range(0, 3)], rand_axis(), rand_axis(), rand_axis());
         // one long receiver hold-off so the pipeline fills and back-pressures
         if (ph == 5) hold_req = 1'b1;
         for (int j = 0; j < 110; j++) position_q.push_back(rand_position());
      end
      drain_pipe();

      $display("covered %0d results over all joint kinds, extreme and random axes,", checked);
      $display("bursty input, random output stalls and a long back-pressure stretch");
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
